// ===== sv/msjs_pkg.sv =====
// Shared constants for the multi-server job scheduler.
package msjs_pkg;
	localparam int MAX_SERVERS_DEF = 8;
	localparam int QUEUE_DEPTH_DEF = 128;

	localparam logic [1:0] MODE_RR   = 2'd0;
	localparam logic [1:0] MODE_FCFS = 2'd1;
	localparam logic [1:0] MODE_SRTF = 2'd2;
	localparam logic [1:0] MODE_RSVD = 2'd3;

	localparam logic [1:0] REG_MODE  = 2'd0;
	localparam logic [1:0] REG_COUNT = 2'd1;
	localparam logic [1:0] REG_SLICE = 2'd2;

	localparam logic OP_ARRIVAL = 1'b0;
	localparam logic OP_TICK    = 1'b1;

	localparam logic KIND_ARRIVAL = 1'b0;
	localparam logic KIND_SERVER  = 1'b1;

	localparam logic ST_QUEUED  = 1'b0;
	localparam logic ST_DROPPED = 1'b1;
endpackage

// ===== sv/msjs_job_if.sv =====
// Request channel carrying job arrivals and time ticks.
interface msjs_job_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [15:0] job_id;
	logic [7:0]  job_weight;
	logic [7:0]  job_quantity;
	modport source (output valid, output opcode, output job_id, output job_weight,
		output job_quantity, input ready);
	modport sink (input valid, input opcode, input job_id, input job_weight,
		input job_quantity, output ready);
endinterface

// ===== sv/msjs_res_if.sv =====
// Result channel carrying arrival and server status.
interface msjs_res_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic        accept_status;
	logic [2:0]  server_index;
	logic        server_busy;
	logic [15:0] held_job_id;
	logic [15:0] work_left;
	logic        last_result;
	modport source (output valid, output result_kind, output accept_status,
		output server_index, output server_busy, output held_job_id, output work_left,
		output last_result, input ready);
	modport sink (input valid, input result_kind, input accept_status,
		input server_index, input server_busy, input held_job_id, input work_left,
		input last_result, output ready);
endinterface

// ===== sv/msjs_cfg_if.sv =====
// Configuration write channel.
interface msjs_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/multi_server_job_scheduler.sv =====
// Multi-server job scheduler with a circular wait queue held in memory.
//
//  Channel | Dir | Handshake     | Payload
//  req     | in  | valid / ready | opcode, job_id, job_weight, job_quantity
//  rsp     | out | valid / ready | kind, status, server index, busy, id, work left, last
//  cfg     | in  | valid / ready | index, data
//
// An arrival writes the queue and reports its status. A tick advances each server,
// then per server scans the queue memory and compacts it in shortest-remaining mode
// or loads an idle server from the queue head in the other modes, then reports each
// server. The queue memory has one read port and one write port.
// Reset clears pointers and server state; the queue memory is not cleared.
// One request is handled at a time; a stalled result holds the sequencer.
module multi_server_job_scheduler
	import msjs_pkg::*;
#(
	parameter int MAX_SERVERS = MAX_SERVERS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	msjs_job_if.sink   req,
	msjs_res_if.source rsp,
	msjs_cfg_if.sink   cfg
);
	localparam int CAP = (MAX_SERVERS < 8) ? MAX_SERVERS : 8;
	localparam int SW  = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
	localparam int PW  = $clog2(QUEUE_DEPTH);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_ARR   = 9'b000000010,
		S_ADV   = 9'b000000100,
		S_PICK  = 9'b000001000,
		S_SCAN  = 9'b000010000,
		S_SHIFT = 9'b000100000,
		S_SWAP  = 9'b001000000,
		S_LOAD  = 9'b010000000,
		S_OUT   = 9'b100000000
	} state_t;

	function automatic logic [PW-1:0] ptr_add(input logic [PW-1:0] a, input logic [PW-1:0] b);
		logic [PW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (PW+1)'(QUEUE_DEPTH))
			s = s - (PW+1)'(QUEUE_DEPTH);
		return s[PW-1:0];
	endfunction

	logic [31:0] mem [QUEUE_DEPTH];
	logic [31:0] rdata_q;
	logic        rd_en;
	logic [PW-1:0] rd_addr;
	logic        we;
	logic [PW-1:0] wa;
	logic [31:0] wd;

	always_ff @(posedge clk) begin
		if (rd_en)
			rdata_q <= mem[rd_addr];
		if (we)
			mem[wa] <= wd;
	end

	state_t state_q;
	logic [1:0]  mode_q;
	logic [3:0]  count_q;
	logic [15:0] slice_q;
	logic [PW-1:0] head_q, tail_q;
	logic [SW-1:0] i_q;
	logic [15:0] id_q, work_q;
	logic        op_q;
	logic [MAX_SERVERS-1:0] busy_q;
	logic [15:0] job_q   [MAX_SERVERS];
	logic [15:0] left_q  [MAX_SERVERS];
	logic [15:0] used_q  [MAX_SERVERS];
	logic [PW-1:0] kr_q, qn_q, k_s1, at_q;
	logic        v_s1, found_q;
	logic [16:0] best_q;
	logic [31:0] ent_q;

	logic        out_v_q, out_kind_q, out_st_q, out_busy_q, out_last_q;
	logic [2:0]  out_idx_q;
	logic [15:0] out_id_q, out_left_q;

	logic [PW-1:0] qcnt, tail_inc;
	logic        qfull, out_free, out_load, last_srv;
	logic [SW-1:0] n_last;
	logic [15:0] used_inc;

	always_comb begin
		if (count_q == 4'd0)
			n_last = '0;
		else if (count_q > 4'(CAP))
			n_last = SW'(CAP - 1);
		else
			n_last = SW'(count_q - 4'd1);
	end

	assign qcnt     = (tail_q >= head_q) ? (tail_q - head_q)
		: PW'({1'b0, tail_q} + (PW+1)'(QUEUE_DEPTH) - {1'b0, head_q});
	assign tail_inc = ptr_add(tail_q, PW'(1));
	assign qfull    = (tail_inc == head_q);
	assign out_free = !out_v_q || rsp.ready;
	assign out_load = out_free && (state_q == S_ARR || state_q == S_OUT);
	assign last_srv = (i_q == n_last);
	assign used_inc = used_q[i_q] + 16'd1;

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = ptr_add(head_q, kr_q);
		we      = 1'b0;
		wa      = tail_q;
		wd      = {job_q[i_q], left_q[i_q]};
		unique case (state_q)
			S_ARR: begin
				we = out_free && !qfull;
				wd = {id_q, work_q};
			end
			S_ADV: begin
				we = busy_q[i_q] && left_q[i_q] > 16'd1 && mode_q == MODE_RR
					&& used_inc == slice_q && !qfull;
				wd = {job_q[i_q], left_q[i_q] - 16'd1};
			end
			S_PICK: begin
				rd_en   = 1'b1;
				rd_addr = head_q;
			end
			S_SCAN: rd_en = (kr_q < qn_q);
			S_SHIFT: begin
				rd_en = (kr_q < qn_q);
				we    = v_s1;
				wa    = ptr_add(head_q, k_s1 - PW'(1));
				wd    = rdata_q;
			end
			S_SWAP: we = busy_q[i_q];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_FCFS;
			count_q <= 4'd1;
			slice_q <= 16'd1;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_MODE:  mode_q  <= cfg.data[1:0];
				REG_COUNT: count_q <= cfg.data[3:0];
				REG_SLICE: slice_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			id_q   <= req.job_id;
			work_q <= 16'(req.job_weight * req.job_quantity);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			i_q     <= '0;
			op_q    <= OP_ARRIVAL;
			busy_q  <= '0;
			for (int s = 0; s < MAX_SERVERS; s++) begin
				job_q[s]  <= '0;
				left_q[s] <= '0;
				used_q[s] <= '0;
			end
			kr_q    <= '0;
			qn_q    <= '0;
			k_s1    <= '0;
			at_q    <= '0;
			v_s1    <= 1'b0;
			found_q <= 1'b0;
			best_q  <= '0;
			ent_q   <= '0;
			out_v_q <= 1'b0;
			out_kind_q <= KIND_ARRIVAL;
			out_st_q   <= ST_QUEUED;
			out_busy_q <= 1'b0;
			out_last_q <= 1'b0;
			out_idx_q  <= '0;
			out_id_q   <= '0;
			out_left_q <= '0;
		end else begin
			if (rsp.valid && rsp.ready && !out_load)
				out_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						op_q    <= req.opcode;
						i_q     <= '0;
						state_q <= (req.opcode == OP_TICK) ? S_ADV : S_ARR;
					end
				end
				S_ARR: begin
					if (out_free) begin
						if (!qfull)
							tail_q <= tail_inc;
						out_v_q    <= 1'b1;
						out_kind_q <= KIND_ARRIVAL;
						out_st_q   <= qfull ? ST_DROPPED : ST_QUEUED;
						out_idx_q  <= '0;
						out_busy_q <= 1'b0;
						out_id_q   <= '0;
						out_left_q <= '0;
						out_last_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				S_ADV: begin
					if (busy_q[i_q]) begin
						if (left_q[i_q] <= 16'd1) begin
							busy_q[i_q] <= 1'b0;
							left_q[i_q] <= '0;
						end else if (mode_q == MODE_RR && used_inc == slice_q) begin
							used_q[i_q] <= '0;
							if (!qfull) begin
								tail_q      <= tail_inc;
								busy_q[i_q] <= 1'b0;
								left_q[i_q] <= '0;
							end else
								left_q[i_q] <= left_q[i_q] - 16'd1;
						end else begin
							left_q[i_q] <= left_q[i_q] - 16'd1;
							if (mode_q == MODE_RR)
								used_q[i_q] <= used_inc;
						end
					end
					if (last_srv) begin
						i_q     <= '0;
						state_q <= S_PICK;
					end else
						i_q <= i_q + SW'(1);
				end
				S_PICK: begin
					kr_q    <= '0;
					qn_q    <= qcnt;
					v_s1    <= 1'b0;
					found_q <= 1'b0;
					best_q  <= busy_q[i_q] ? {1'b0, left_q[i_q]} : 17'h10000;
					if (mode_q == MODE_SRTF && (busy_q[i_q] || qcnt != '0))
						state_q <= S_SCAN;
					else if (mode_q != MODE_SRTF && !busy_q[i_q] && qcnt != '0)
						state_q <= S_LOAD;
					else if (last_srv) begin
						i_q     <= '0;
						state_q <= S_OUT;
					end else
						i_q <= i_q + SW'(1);
				end
				S_SCAN: begin
					v_s1 <= (kr_q < qn_q);
					k_s1 <= kr_q;
					if (kr_q < qn_q)
						kr_q <= kr_q + PW'(1);
					if (v_s1 && {1'b0, rdata_q[15:0]} < best_q) begin
						best_q  <= {1'b0, rdata_q[15:0]};
						at_q    <= k_s1;
						ent_q   <= rdata_q;
						found_q <= 1'b1;
					end
					if (!(kr_q < qn_q) && !v_s1) begin
						if (!found_q) begin
							if (last_srv) begin
								i_q     <= '0;
								state_q <= S_OUT;
							end else begin
								i_q     <= i_q + SW'(1);
								state_q <= S_PICK;
							end
						end else if (at_q == '0) begin
							head_q  <= ptr_add(head_q, PW'(1));
							state_q <= S_SWAP;
						end else begin
							kr_q    <= at_q + PW'(1);
							state_q <= S_SHIFT;
						end
					end
				end
				S_SHIFT: begin
					v_s1 <= (kr_q < qn_q);
					k_s1 <= kr_q;
					if (kr_q < qn_q)
						kr_q <= kr_q + PW'(1);
					if (!(kr_q < qn_q) && !v_s1) begin
						tail_q  <= ptr_add(tail_q, PW'(QUEUE_DEPTH - 1));
						state_q <= S_SWAP;
					end
				end
				S_SWAP: begin
					if (busy_q[i_q])
						tail_q <= tail_inc;
					busy_q[i_q] <= 1'b1;
					job_q[i_q]  <= ent_q[31:16];
					left_q[i_q] <= ent_q[15:0];
					used_q[i_q] <= '0;
					if (last_srv) begin
						i_q     <= '0;
						state_q <= S_OUT;
					end else begin
						i_q     <= i_q + SW'(1);
						state_q <= S_PICK;
					end
				end
				S_LOAD: begin
					head_q      <= ptr_add(head_q, PW'(1));
					busy_q[i_q] <= 1'b1;
					job_q[i_q]  <= rdata_q[31:16];
					left_q[i_q] <= rdata_q[15:0];
					used_q[i_q] <= '0;
					if (last_srv) begin
						i_q     <= '0;
						state_q <= S_OUT;
					end else begin
						i_q     <= i_q + SW'(1);
						state_q <= S_PICK;
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_v_q    <= 1'b1;
						out_kind_q <= KIND_SERVER;
						out_st_q   <= ST_QUEUED;
						out_idx_q  <= 3'(i_q);
						out_busy_q <= busy_q[i_q];
						out_id_q   <= busy_q[i_q] ? job_q[i_q] : '0;
						out_left_q <= busy_q[i_q] ? left_q[i_q] : '0;
						out_last_q <= last_srv;
						if (last_srv)
							state_q <= S_IDLE;
						else
							i_q <= i_q + SW'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid         = out_v_q;
	assign rsp.result_kind   = out_kind_q;
	assign rsp.accept_status = out_st_q;
	assign rsp.server_index  = out_idx_q;
	assign rsp.server_busy   = out_busy_q;
	assign rsp.held_job_id   = out_id_q;
	assign rsp.work_left     = out_left_q;
	assign rsp.last_result   = out_last_q;

	a_arr_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.result_kind == KIND_ARRIVAL |-> rsp.last_result)
		else $error("Arrival status is not marked last.");
	a_req_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> state_q != S_IDLE)
		else $error("Accepted request did not start the sequencer.");
	a_found_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SHIFT |-> found_q && at_q < qn_q)
		else $error("Queue compaction started without a valid entry.");
	a_arr_op: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ARR |-> op_q == OP_ARRIVAL)
		else $error("Arrival handling entered for a tick request.");
endmodule

// ===== test/tb_top.sv =====
// Testbench for the multi-server job scheduler: random and directed requests checked against a predictor.
module tb_top;
	import msjs_pkg::*;

	typedef struct packed {
		logic        opcode;
		logic [15:0] job_id;
		logic [7:0]  job_weight;
		logic [7:0]  job_quantity;
	} job_req_t;

	typedef struct packed {
		logic        result_kind;
		logic        accept_status;
		logic [2:0]  server_index;
		logic        server_busy;
		logic [15:0] held_job_id;
		logic [15:0] work_left;
		logic        last_result;
	} status_t;

	localparam int QDEPTH = QUEUE_DEPTH_DEF;
	localparam int NSRV = MAX_SERVERS_DEF;
	localparam int STALL_LIMIT = 200000;

	logic clk;
	logic arst_n;
	msjs_job_if req();
	msjs_res_if rsp();
	msjs_cfg_if cfg();

	multi_server_job_scheduler dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .cfg(cfg));

	job_req_t pending_reqs[$];
	status_t expected_status[$];
	int mismatches = 0;
	bit quiet_phase = 0;
	int idle_cycles = 0;
	bit req_fire = 0;

	// Scheduler state mirror.
	logic [31:0] wq[QDEPTH];
	int q_head, q_tail;
	logic        s_busy[NSRV];
	logic [15:0] s_job[NSRV];
	logic [15:0] s_left[NSRV];
	logic [15:0] s_slice[NSRV];
	logic [1:0]  m_mode;
	logic [3:0]  m_count;
	logic [15:0] m_slice;

	function automatic int qcount();
		return (q_tail + QDEPTH - q_head) % QDEPTH;
	endfunction

	function automatic bit qpush(logic [31:0] e);
		int nt;
		nt = (q_tail + 1) % QDEPTH;
		if (nt == q_head)
			return 0;
		wq[q_tail] = e;
		q_tail = nt;
		return 1;
	endfunction

	function automatic void qremove(int k);
		int n;
		n = qcount();
		if (k >= n)
			return;
		if (k == 0) begin
			q_head = (q_head + 1) % QDEPTH;
			return;
		end
		for (int j = k; j + 1 < n; j++)
			wq[(q_head + j) % QDEPTH] = wq[(q_head + j + 1) % QDEPTH];
		q_tail = (q_tail + QDEPTH - 1) % QDEPTH;
	endfunction

	function automatic int find_shortest(int lim);
		int best, at;
		best = lim;
		at = -1;
		for (int k = 0; k < qcount(); k++)
			if (int'(wq[(q_head + k) % QDEPTH][15:0]) < best) begin
				best = wq[(q_head + k) % QDEPTH][15:0];
				at = k;
			end
		return at;
	endfunction

	function automatic void take_job(int i, logic [31:0] e);
		s_busy[i] = 1;
		s_job[i] = e[31:16];
		s_left[i] = e[15:0];
		s_slice[i] = 0;
	endfunction

	function automatic void predict_schedule(job_req_t r);
		status_t st;
		int n, k;
		logic [31:0] e;
		logic [15:0] work;
		if (r.opcode == OP_ARRIVAL) begin
			work = r.job_weight * r.job_quantity;
			st = '0;
			st.result_kind = KIND_ARRIVAL;
			st.accept_status = qpush({r.job_id, work}) ? ST_QUEUED : ST_DROPPED;
			st.last_result = 1;
			expected_status.push_back(st);
			return;
		end
		n = (m_count == 0) ? 1 : (m_count > NSRV ? NSRV : m_count);
		for (int i = 0; i < n; i++) begin
			if (!s_busy[i])
				continue;
			if (s_left[i] <= 1) begin
				s_busy[i] = 0;
				s_left[i] = 0;
				continue;
			end
			s_left[i]--;
			if (m_mode == MODE_RR) begin
				s_slice[i]++;
				if (s_slice[i] == m_slice) begin
					s_slice[i] = 0;
					if (qpush({s_job[i], s_left[i]})) begin
						s_busy[i] = 0;
						s_left[i] = 0;
					end
				end
			end
		end
		for (int i = 0; i < n; i++) begin
			if (m_mode == MODE_SRTF) begin
				if (s_busy[i]) begin
					k = find_shortest(s_left[i]);
					if (k >= 0) begin
						e = wq[(q_head + k) % QDEPTH];
						qremove(k);
						void'(qpush({s_job[i], s_left[i]}));
						take_job(i, e);
					end
				end else if (qcount() > 0) begin
					k = find_shortest(32'h10000);
					if (k < 0)
						k = 0;
					e = wq[(q_head + k) % QDEPTH];
					qremove(k);
					take_job(i, e);
				end
			end else if (!s_busy[i] && qcount() > 0) begin
				e = wq[q_head];
				qremove(0);
				take_job(i, e);
			end
		end
		for (int i = 0; i < n; i++) begin
			st = '0;
			st.result_kind = KIND_SERVER;
			st.server_index = 3'(i);
			st.server_busy = s_busy[i];
			st.held_job_id = s_busy[i] ? s_job[i] : 16'd0;
			st.work_left = s_busy[i] ? s_left[i] : 16'd0;
			st.last_result = (i + 1 == n);
			expected_status.push_back(st);
		end
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h", what, got, want);
		mismatches++;
	endtask

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// Request driver.
	always @(negedge clk) begin
		if (!req.valid || req_fire) begin
			if (pending_reqs.size() > 0 && arst_n &&
				(quiet_phase || $urandom_range(99) >= 35)) begin
				req.valid <= 1;
				{req.opcode, req.job_id, req.job_weight, req.job_quantity} <= pending_reqs[0];
			end else
				req.valid <= 0;
		end
		rsp.ready <= quiet_phase || $urandom_range(99) >= 35;
	end

	// Monitor: prediction at request acceptance, comparison at result acceptance.
	always @(posedge clk) begin
		status_t want;
		req_fire <= req.valid && req.ready;
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (req.valid && req.ready)
			predict_schedule(pending_reqs.pop_front());
		if (rsp.valid && rsp.ready) begin
			if (expected_status.size() == 0)
				report("unexpected result", 0, 0);
			else begin
				want = expected_status.pop_front();
				if (rsp.result_kind !== want.result_kind)
					report("result_kind", rsp.result_kind, want.result_kind);
				if (rsp.accept_status !== want.accept_status)
					report("accept_status", rsp.accept_status, want.accept_status);
				if (rsp.server_index !== want.server_index)
					report("server_index", rsp.server_index, want.server_index);
				if (rsp.server_busy !== want.server_busy)
					report("server_busy", rsp.server_busy, want.server_busy);
				if (rsp.held_job_id !== want.held_job_id)
					report("held_job_id", rsp.held_job_id, want.held_job_id);
				if (rsp.work_left !== want.work_left)
					report("work_left", rsp.work_left, want.work_left);
				if (rsp.last_result !== want.last_result)
					report("last_result", rsp.last_result, want.last_result);
			end
		end
		if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_MODE: m_mode = cfg.data[1:0];
				REG_COUNT: m_count = cfg.data[3:0];
				REG_SLICE: m_slice = cfg.data;
				default: ;
			endcase
		end
		if (idle_cycles > STALL_LIMIT) begin
			$display("[multi_server_job_scheduler] ERROR");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || expected_status.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg.valid <= 1;
		cfg.index <= idx;
		cfg.data <= val;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		@(negedge clk);
		cfg.valid <= 0;
	endtask

	task automatic add_req(logic op, logic [15:0] id, logic [7:0] w, logic [7:0] q);
		job_req_t r;
		r = {op, id, w, q};
		pending_reqs.push_back(r);
	endtask

	task automatic random_phase(int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 55)
				add_req(OP_ARRIVAL, 16'($urandom),
					8'($urandom_range(3) == 0 ? $urandom : $urandom_range(4)),
					8'($urandom_range(3) == 0 ? $urandom : $urandom_range(5)));
			else
				add_req(OP_TICK, 16'($urandom), 8'($urandom), 8'($urandom));
		end
	endtask

	initial begin
		logic [1:0] modes[5] = '{MODE_FCFS, MODE_RR, MODE_SRTF, MODE_RSVD, MODE_RR};
		logic [3:0] counts[5] = '{4'd1, 4'd8, 4'd3, 4'd0, 4'd15};
		logic [15:0] slices[5] = '{16'd1, 16'd2, 16'd65535, 16'd3, 16'd0};
		req.valid = 0;
		req.opcode = 0;
		req.job_id = 0;
		req.job_weight = 0;
		req.job_quantity = 0;
		rsp.ready = 0;
		cfg.valid = 0;
		cfg.index = 0;
		cfg.data = 0;
		q_head = 0;
		q_tail = 0;
		for (int i = 0; i < NSRV; i++) begin
			s_busy[i] = 0;
			s_job[i] = 0;
			s_left[i] = 0;
			s_slice[i] = 0;
		end
		m_mode = MODE_FCFS;
		m_count = 1;
		m_slice = 1;
		arst_n = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: extremes, zero work, queue overflow, all ops.
		add_req(OP_ARRIVAL, 16'hFFFF, 8'hFF, 8'hFF);
		add_req(OP_ARRIVAL, 16'h0000, 8'h00, 8'hFF);
		add_req(OP_ARRIVAL, 16'h1234, 8'h02, 8'h00);
		add_req(OP_TICK, 0, 0, 0);
		add_req(OP_TICK, 16'hFFFF, 8'hFF, 8'hFF);
		add_req(OP_TICK, 0, 0, 0);
		add_req(OP_ARRIVAL, 16'h00AA, 8'h01, 8'h02);
		add_req(OP_TICK, 0, 0, 0);
		wait_drained();
		for (int i = 0; i < 130; i++)
			add_req(OP_ARRIVAL, 16'(i), 1, 1);
		add_req(OP_TICK, 0, 0, 0);
		add_req(OP_ARRIVAL, 16'h5555, 8'h80, 8'h01);
		wait_drained();

		for (int p = 0; p < 5; p++) begin
			write_reg(REG_MODE, modes[p]);
			write_reg(REG_COUNT, counts[p]);
			write_reg(REG_SLICE, slices[p]);
			quiet_phase = (p == 2);
			// Drain leftovers so the queue does not stay full.
			random_phase(24);
			for (int t = 0; t < 12; t++)
				add_req(OP_TICK, 0, 0, 0);
			wait_drained();
		end
		if (mismatches == 0)
			$display("[multi_server_job_scheduler] OK");
		else
			$display("[multi_server_job_scheduler] ERROR");
		$finish;
	end
endmodule

// ===== sim.f =====
sv/msjs_pkg.sv
sv/msjs_job_if.sv
sv/msjs_res_if.sv
sv/msjs_cfg_if.sv
sv/multi_server_job_scheduler.sv
test/tb_top.sv
